### rtl/qfts_pkg.sv
package qfts_pkg;

    localparam int DEPTH_DEF = 128;

    localparam int FUNC_W   = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd128;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ   = 2'd0,
        FN_DEQ   = 2'd1,
        FN_FRONT = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

endpackage

### rtl/queue_from_two_stacks.sv
// FIFO of signed 32-bit values held in two stacks. Send one item per
// operation on the slave stream: tuser selects enqueue, dequeue or front,
// tdata carries the value to enqueue; each item gives exactly one result
// (tdata value, tuser status ok/full/empty). Enqueue and empty-queue or
// unused-code items are answered straight from the accept state; dequeue/front
// with a non-empty outbound stack go through accept, RAM read and result;
// when the outbound stack is empty the pour sequencer first moves the
// inbound stack across at one entry per cycle through the stack RAMs (one
// write and one registered read port each).
// tready drops while an item is in work or while a result is held behind a
// stalled output register. Stack RAM contents need no clearing after reset.
module queue_from_two_stacks #(
    parameter int DEPTH = qfts_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qfts_pkg::LIMIT_W-1:0]  i_cfg_wdata,     // queue_limit
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [qfts_pkg::DATA_W-1:0]   i_s_axis_tdata,  // [31:0] value
    input  logic [qfts_pkg::FUNC_W-1:0]   i_s_axis_tuser,  // [1:0] func
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [qfts_pkg::DATA_W-1:0]   o_m_axis_tdata,  // [31:0] data
    output logic [qfts_pkg::STATUS_W-1:0] o_m_axis_tuser   // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                        ib_we, ob_we;
    logic [AW-1:0]               ib_waddr, ib_raddr, ob_waddr, ob_raddr;
    logic [qfts_pkg::DATA_W-1:0] ib_wdata, ib_rdata, ob_wdata, ob_rdata;

    qfts_ram #(.DEPTH(DEPTH), .AW(AW)) u_ib_ram (
        .i_clk   (i_clk),
        .i_we    (ib_we),
        .i_waddr (ib_waddr),
        .i_wdata (ib_wdata),
        .i_raddr (ib_raddr),
        .o_rdata (ib_rdata)
    );

    qfts_ram #(.DEPTH(DEPTH), .AW(AW)) u_ob_ram (
        .i_clk   (i_clk),
        .i_we    (ob_we),
        .i_waddr (ob_waddr),
        .i_wdata (ob_wdata),
        .i_raddr (ob_raddr),
        .o_rdata (ob_rdata)
    );

    qfts_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_ib_we         (ib_we),
        .o_ib_waddr      (ib_waddr),
        .o_ib_wdata      (ib_wdata),
        .o_ib_raddr      (ib_raddr),
        .i_ib_rdata      (ib_rdata),
        .o_ob_we         (ob_we),
        .o_ob_waddr      (ob_waddr),
        .o_ob_wdata      (ob_wdata),
        .o_ob_raddr      (ob_raddr),
        .i_ob_rdata      (ob_rdata)
    );

endmodule

### rtl/qfts_ram.sv
module qfts_ram #(
    parameter int DEPTH = qfts_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [qfts_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [qfts_pkg::DATA_W-1:0] o_rdata
);

    logic [qfts_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [qfts_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/qfts_ctrl.sv
module qfts_ctrl #(
    parameter int DEPTH = qfts_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qfts_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [qfts_pkg::DATA_W-1:0]   i_s_axis_tdata,
    input  logic [qfts_pkg::FUNC_W-1:0]   i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [qfts_pkg::DATA_W-1:0]   o_m_axis_tdata,
    output logic [qfts_pkg::STATUS_W-1:0] o_m_axis_tuser,
    output logic                          o_ib_we,
    output logic [AW-1:0]                 o_ib_waddr,
    output logic [qfts_pkg::DATA_W-1:0]   o_ib_wdata,
    output logic [AW-1:0]                 o_ib_raddr,
    input  logic [qfts_pkg::DATA_W-1:0]   i_ib_rdata,
    output logic                          o_ob_we,
    output logic [AW-1:0]                 o_ob_waddr,
    output logic [qfts_pkg::DATA_W-1:0]   o_ob_wdata,
    output logic [AW-1:0]                 o_ob_raddr,
    input  logic [qfts_pkg::DATA_W-1:0]   i_ob_rdata
);

    localparam int LW = (CW > qfts_pkg::LIMIT_W) ? CW : qfts_pkg::LIMIT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POUR = 5'b00010,
        S_PEEK = 5'b00100,
        S_LOAD = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [qfts_pkg::LIMIT_W-1:0]  r_queue_limit;
    logic [CW-1:0]                 r_in_cnt, n_in_cnt;
    logic [CW-1:0]                 r_out_cnt, n_out_cnt;
    logic                          r_mv, n_mv;
    logic                          r_deq, n_deq;
    logic [qfts_pkg::DATA_W-1:0]   r_hold_data, n_hold_data;
    logic [qfts_pkg::STATUS_W-1:0] r_hold_status, n_hold_status;
    logic                          r_out_valid, n_out_valid;
    logic [qfts_pkg::DATA_W-1:0]   r_out_data, n_out_data;
    logic [qfts_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    logic                          accept;
    logic                          full;
    logic [LW-1:0]                 lim_w, eff_lim;
    logic                          fin;
    logic [qfts_pkg::DATA_W-1:0]   fin_data;
    logic [qfts_pkg::STATUS_W-1:0] fin_status;
    logic                          out_free;
    logic                          pour_rd;
    qfts_pkg::t_func               func;

    assign func    = qfts_pkg::t_func'(i_s_axis_tuser);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // limit clamped to 1..DEPTH
    always_comb begin
        lim_w = LW'(r_queue_limit);
        if (lim_w == '0) begin
            eff_lim = LW'(1);
        end else if (lim_w > LW'(DEPTH)) begin
            eff_lim = LW'(DEPTH);
        end else begin
            eff_lim = lim_w;
        end
    end
    assign full = LW'(r_in_cnt) >= eff_lim;

    assign pour_rd    = (r_state == S_POUR) && (r_in_cnt != '0);
    assign o_ib_raddr = AW'(r_in_cnt - CW'(1));
    assign o_ob_raddr = AW'(r_out_cnt - CW'(1));

    assign o_ib_we    = accept && (func == qfts_pkg::FN_ENQ) && !full;
    assign o_ib_waddr = r_in_cnt[AW-1:0];
    assign o_ib_wdata = i_s_axis_tdata;

    // item read in the previous cycle lands on the outbound top
    assign o_ob_we    = r_mv;
    assign o_ob_waddr = r_out_cnt[AW-1:0];
    assign o_ob_wdata = i_ib_rdata;

    always_comb begin
        n_state       = r_state;
        n_in_cnt      = r_in_cnt;
        n_out_cnt     = r_out_cnt;
        n_mv          = 1'b0;
        n_deq         = r_deq;
        n_hold_data   = r_hold_data;
        n_hold_status = r_hold_status;
        fin           = 1'b0;
        fin_data      = '0;
        fin_status    = qfts_pkg::ST_OK;

        if (o_ib_we) begin
            n_in_cnt = r_in_cnt + CW'(1);
        end
        if (r_mv) begin
            n_out_cnt = r_out_cnt + CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_deq = (func == qfts_pkg::FN_DEQ);
                    case (func)
                        qfts_pkg::FN_ENQ: begin
                            fin      = 1'b1;
                            fin_data = i_s_axis_tdata;
                            fin_status = full ? qfts_pkg::ST_FULL : qfts_pkg::ST_OK;
                        end
                        qfts_pkg::FN_DEQ, qfts_pkg::FN_FRONT: begin
                            if (r_in_cnt == '0 && r_out_cnt == '0) begin
                                fin        = 1'b1;
                                fin_data   = qfts_pkg::EMPTY_DATA;
                                fin_status = qfts_pkg::ST_EMPTY;
                            end else if (r_out_cnt == '0) begin
                                n_state = S_POUR;
                            end else begin
                                n_state = S_PEEK;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_POUR: begin
                if (pour_rd) begin
                    n_in_cnt = r_in_cnt - CW'(1);
                    n_mv     = 1'b1;
                end else begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                fin      = 1'b1;
                fin_data = i_ob_rdata;
                if (r_deq) begin
                    n_out_cnt = r_out_cnt - CW'(1);
                end
            end
            S_HOLD: begin
                fin        = 1'b1;
                fin_data   = r_hold_data;
                fin_status = r_hold_status;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_state = S_IDLE;
            end else begin
                n_state       = S_HOLD;
                n_hold_data   = fin_data;
                n_hold_status = fin_status;
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (fin && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = fin_data;
            n_out_status = fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_queue_limit <= qfts_pkg::LIMIT_RST;
            r_in_cnt      <= '0;
            r_out_cnt     <= '0;
            r_mv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_mv        <= n_mv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_queue_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_deq         <= n_deq;
        r_hold_data   <= n_hold_data;
        r_hold_status <= n_hold_status;
        r_out_data    <= n_out_data;
        r_out_status  <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    logic [CW:0] total;
    assign total = {1'b0, r_in_cnt} + {1'b0, r_out_cnt} + (CW+1)'(r_mv);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_cnt <= CW'(DEPTH)) && (r_out_cnt <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    a_pour_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POUR) |=> (total == $past(total)))
        else $error("item lost or duplicated during pour");

    a_peek_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEEK) |-> (r_out_cnt != '0))
        else $error("peek on empty outbound stack");

    a_enq_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ib_we |=> (r_in_cnt == $past(r_in_cnt) + CW'(1)))
        else $error("enqueue did not advance inbound count");

endmodule
